// ===== rtl/core/v3n_pkg.sv =====
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants for the vector normalizer
// Widths of the component, square-sum, root and quotient paths.
// ----------------------------------------------------------------------------
`default_nettype none

package v3n_pkg;

    localparam int COMPONENT_BITS       = 24;
    localparam int RESULT_FRACTION_BITS = 30;
    localparam int OUT_BITS             = 32;

    localparam int MAG_BITS  = COMPONENT_BITS;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int ROOT_BITS = SUM_BITS / 2;
    localparam int Q_BITS    = RESULT_FRACTION_BITS + 1;

    // square root: one result bit per stage
    localparam int SQRT_STAGES = ROOT_BITS;
    // divider: one quotient bit per stage
    localparam int DIV_STAGES  = RESULT_FRACTION_BITS;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] comp_x;
        logic signed [COMPONENT_BITS-1:0] comp_y;
        logic signed [COMPONENT_BITS-1:0] comp_z;
    } v3n_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] unit_x;
        logic signed [OUT_BITS-1:0] unit_y;
        logic signed [OUT_BITS-1:0] unit_z;
        logic                       was_zero;
    } v3n_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/vector3_normalizer.sv =====
// ----------------------------------------------------------------------------
// vector3_normalizer: scales a 3-component vector to unit length
// Channels: in (valid/stall, v3n_in_t) and out (valid/stall, v3n_out_t).
// A word is accepted when valid is high and stall is low.
// Pipeline: magnitude/square stage, sum stage, a 25-stage square root
// (one root bit per stage), then three parallel divide lanes of 30 stages
// (one quotient bit each) and a sign stage that is the output register.
// Depth: 2 + 25 + 30 + 1 = 58 register stages from in_data to out_data.
// Throughput: one word per cycle unless stalled; the pipe advances as one unit.
// Stall: when out is stalled with a word held, the pipe freezes and in_stall
// rises in the same cycle; an empty output slot lets the pipe advance, but
// bubbles inside the pipe are not squeezed out.
// Zero vector: all unit fields are 0 and was_zero is 1.
// Reset: clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_normalizer
    import v3n_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire v3n_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output v3n_out_t      out_data
);

    logic en;
    // advance when the output slot is free or being taken
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // stage 1: magnitudes and squares
    logic                 v1_reg;
    logic [MAG_BITS-1:0]  mag_reg [3];
    logic [2:0]           neg_reg;
    logic [SQ_BITS-1:0]   sq_reg  [3];

    logic [COMPONENT_BITS-1:0] raw [3];
    logic [MAG_BITS-1:0]       mag_c [3];
    always_comb
    begin
        raw[0] = in_data.comp_x;
        raw[1] = in_data.comp_y;
        raw[2] = in_data.comp_z;
        for (int i = 0; i < 3; i++)
            mag_c[i] = raw[i][COMPONENT_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= mag_c[i];
                neg_reg[i] <= raw[i][COMPONENT_BITS-1];
                sq_reg[i]  <= SQ_BITS'(mag_c[i]) * SQ_BITS'(mag_c[i]);
            end
        end
    end

    // stage 2: sum of squares
    logic                v2_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [3*MAG_BITS+3:0] side2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1])
                     + SUM_BITS'(sq_reg[2]);
            side2_reg <= {mag_reg[0], mag_reg[1], mag_reg[2], neg_reg,
                          (mag_reg[0] == '0) && (mag_reg[1] == '0)
                          && (mag_reg[2] == '0)};
        end
    end

    // square root
    logic                  vs;
    logic [ROOT_BITS-1:0]  root;
    logic [3*MAG_BITS+3:0] side_s;

    v3n_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_sum    (sum_reg),
        .in_side   (side2_reg),
        .out_valid (vs),
        .out_root  (root),
        .out_side  (side_s)
    );

    // lanes; a zero root gives garbage that the merge masks
    // side word: {mag x, mag y, mag z, neg z, neg y, neg x, zero}
    logic signed [OUT_BITS-1:0] unit [3];
    for (genvar i = 0; i < 3; i++) begin : g_lane
        v3n_lane u_lane (
            .clk  (clk),
            .en   (en),
            .mag  (side_s[3*MAG_BITS+3-i*MAG_BITS -: MAG_BITS]),
            .neg  (side_s[1+i]),
            .root (root),
            .unit (unit[i])
        );
    end

    // valid and zero flag delay alongside the lanes
    logic [DIV_STAGES:0] vd_reg;
    logic [DIV_STAGES:0] zd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else if (en)
            vd_reg <= {vd_reg[DIV_STAGES-1:0], vs};
    end
    always_ff @(posedge clk)
    begin
        if (en)
            zd_reg <= {zd_reg[DIV_STAGES-1:0], side_s[0]};
    end

    // merge: output register is the lane's final stage
    assign out_valid         = vd_reg[DIV_STAGES];
    assign out_data.was_zero = zd_reg[DIV_STAGES];
    assign out_data.unit_x   = zd_reg[DIV_STAGES] ? '0 : unit[0];
    assign out_data.unit_y   = zd_reg[DIV_STAGES] ? '0 : unit[1];
    assign out_data.unit_z   = zd_reg[DIV_STAGES] ? '0 : unit[2];

endmodule

`default_nettype wire

// ===== rtl/core/v3n_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3n_sqrt: pipelined floor square root
// One root bit per stage, restoring method; side data rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_sqrt
    import v3n_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [SUM_BITS-1:0] in_sum,
    input  wire logic [3*MAG_BITS+3:0] in_side,
    output logic                     out_valid,
    output logic [ROOT_BITS-1:0]     out_root,
    output logic [3*MAG_BITS+3:0]    out_side
);

    localparam int SIDE_BITS = 3 * MAG_BITS + 4;

    logic [SQRT_STAGES:0]  vld_reg;
    logic [SUM_BITS-1:0]   rad_reg  [SQRT_STAGES+1];
    logic [ROOT_BITS+1:0]  rem_reg  [SQRT_STAGES+1];
    logic [ROOT_BITS-1:0]  root_reg [SQRT_STAGES+1];
    logic [SIDE_BITS-1:0]  side_reg [SQRT_STAGES+1];

    always_comb
    begin
        vld_reg[0]  = in_valid;
        rad_reg[0]  = in_sum;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        side_reg[0] = in_side;
    end

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic [ROOT_BITS+1:0] rem_sh;
        logic [ROOT_BITS+1:0] trial;
        always_comb
        begin
            rem_sh = {rem_reg[s][ROOT_BITS-1:0], rad_reg[s][SUM_BITS-1 -: 2]};
            trial  = {root_reg[s], 2'b01};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s+1]  <= {rad_reg[s][SUM_BITS-3:0], 2'b00};
                side_reg[s+1] <= side_reg[s];
                if (rem_sh >= trial)
                begin
                    rem_reg[s+1]  <= rem_sh - trial;
                    root_reg[s+1] <= {root_reg[s][ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1]  <= rem_sh;
                    root_reg[s+1] <= {root_reg[s][ROOT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES];
    assign out_root  = root_reg[SQRT_STAGES];
    assign out_side  = side_reg[SQRT_STAGES];

endmodule

`default_nettype wire

// ===== rtl/core/v3n_lane.sv =====
// ----------------------------------------------------------------------------
// v3n_lane: one component lane
// Pipelined restoring fraction divide mag*2^F/root, then sign applied.
// ----------------------------------------------------------------------------
`default_nettype none

module v3n_lane
    import v3n_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [MAG_BITS-1:0]  mag,
    input  wire logic                 neg,
    input  wire logic [ROOT_BITS-1:0] root,
    output logic signed [OUT_BITS-1:0] unit
);

    localparam int R_BITS = ROOT_BITS + 1;

    logic [R_BITS-1:0]    rem_reg  [DIV_STAGES+1];
    logic [Q_BITS-1:0]    q_reg    [DIV_STAGES+1];
    logic [ROOT_BITS-1:0] den_reg  [DIV_STAGES+1];
    logic                 neg_reg  [DIV_STAGES+1];
    logic                 full_reg [DIV_STAGES+1];
    logic signed [OUT_BITS-1:0] unit_reg;

    // mag <= root always; mag == root means exactly 1.0
    always_comb
    begin
        rem_reg[0]  = R_BITS'(mag);
        q_reg[0]    = '0;
        den_reg[0]  = root;
        neg_reg[0]  = neg;
        full_reg[0] = (ROOT_BITS'(mag) >= root);
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [R_BITS-1:0] rem_sh;
        always_comb
            rem_sh = {rem_reg[s][R_BITS-2:0], 1'b0};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s+1]  <= den_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                full_reg[s+1] <= full_reg[s];
                if (rem_sh >= R_BITS'(den_reg[s]))
                begin
                    rem_reg[s+1] <= rem_sh - R_BITS'(den_reg[s]);
                    q_reg[s+1]   <= {q_reg[s][Q_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= rem_sh;
                    q_reg[s+1]   <= {q_reg[s][Q_BITS-2:0], 1'b0};
                end
            end
        end
    end

    logic [OUT_BITS-1:0] mag_q;
    always_comb
    begin
        if (full_reg[DIV_STAGES])
            mag_q = OUT_BITS'(64'd1 << RESULT_FRACTION_BITS);
        else
            mag_q = OUT_BITS'(q_reg[DIV_STAGES]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            unit_reg <= neg_reg[DIV_STAGES] ? -$signed(mag_q) : $signed(mag_q);
    end

    assign unit = unit_reg;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector3_normalizer
// Directed table of vectors (extremes, zero, axes, tiny vectors), then random
// words under bursty input and patterned output stall; every result word is
// checked against a fixed expected word or a bit-true normalization predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import v3n_pkg::*;

    localparam int N_RANDOM = 430;
    localparam int DRAIN_CYCLES = 200;
    localparam int IN_BITS = $bits(v3n_in_t);

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    v3n_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    v3n_out_t out_data;

    // expected result words, oldest first
    v3n_out_t expected_q[$];
    int       mismatch_count;
    bit       hold_off;
    bit       stim_done;

    typedef struct {
        v3n_in_t  vec;
        bit       has_fixed;
        v3n_out_t fixed;
    } dir_row_t;

    dir_row_t dir_rows[$];

    vector3_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (s >= root + bitv)
            begin
                s = s - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic v3n_out_t normalize(input v3n_in_t v);
        logic [63:0] mag [3];
        bit          neg [3];
        logic [63:0] sum;
        logic [63:0] root;
        logic [63:0] q;
        logic [63:0] rem;
        logic signed [COMPONENT_BITS-1:0] c [3];
        logic [OUT_BITS-1:0] res [3];
        v3n_out_t r;
        c[0] = v.comp_x;
        c[1] = v.comp_y;
        c[2] = v.comp_z;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = c[i][COMPONENT_BITS-1];
            mag[i] = neg[i] ? (64'd1 << COMPONENT_BITS) - 64'(unsigned'(c[i]))
                            : 64'(unsigned'(c[i]));
            sum += mag[i] * mag[i];
        end
        r = '0;
        if (sum == 0)
        begin
            r.was_zero = 1'b1;
            return r;
        end
        root = floor_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            if (mag[i] >= root)
                q = 64'd1 << RESULT_FRACTION_BITS;
            else
            begin
                rem = mag[i];
                q = '0;
                for (int k = 0; k < RESULT_FRACTION_BITS; k++)
                begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= root)
                    begin
                        rem -= root;
                        q[0] = 1'b1;
                    end
                end
            end
            if (neg[i])
                q = 64'd0 - q;
            res[i] = q[OUT_BITS-1:0];
        end
        r.unit_x = res[0];
        r.unit_y = res[1];
        r.unit_z = res[2];
        return r;
    endfunction

    function automatic v3n_out_t unit_word(input int sx, input int sy, input int sz,
                                           input bit zero);
        v3n_out_t r;
        r.unit_x = sx * (1 << RESULT_FRACTION_BITS);
        r.unit_y = sy * (1 << RESULT_FRACTION_BITS);
        r.unit_z = sz * (1 << RESULT_FRACTION_BITS);
        r.was_zero = zero;
        return r;
    endfunction

    task automatic add_row(input int x, input int y, input int z, input bit fixed,
                           input v3n_out_t res);
        dir_row_t row;
        row.vec.comp_x = COMPONENT_BITS'(x);
        row.vec.comp_y = COMPONENT_BITS'(y);
        row.vec.comp_z = COMPONENT_BITS'(z);
        row.has_fixed = fixed;
        row.fixed = res;
        dir_rows.push_back(row);
    endtask

    function automatic v3n_in_t rand_vector();
        v3n_in_t v;
        int mode;
        mode = $urandom_range(0, 9);
        v = IN_BITS'({$urandom, $urandom, $urandom});
        if (mode < 3)
        begin
            // small vectors: tiny roots, coarse quotients
            v.comp_x = COMPONENT_BITS'($signed($urandom_range(0, 14)) - 7);
            v.comp_y = COMPONENT_BITS'($signed($urandom_range(0, 14)) - 7);
            v.comp_z = COMPONENT_BITS'($signed($urandom_range(0, 14)) - 7);
        end
        else if (mode == 3)
        begin
            // near one axis
            v.comp_y = COMPONENT_BITS'($signed($urandom_range(0, 6)) - 3);
            v.comp_z = COMPONENT_BITS'($signed($urandom_range(0, 6)) - 3);
        end
        return v;
    endfunction

    // sender: bursts with gaps, pressure pause in the middle
    task automatic send_word(input v3n_in_t v, input v3n_out_t res);
        in_valid <= 1'b1;
        in_data  <= v;
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(res);
        @(negedge clk);
    endtask

    task automatic maybe_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return;
        end
        burst = $urandom_range(0, 20);
        in_valid <= 1'b0;
        in_data  <= IN_BITS'({$urandom, $urandom, $urandom});
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    initial
    begin
        v3n_in_t v;
        int burst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        stim_done = 1'b0;
        mismatch_count = 0;
        burst = 0;

        add_row(0, 0, 0, 1, unit_word(0, 0, 0, 1));
        add_row(1, 1, 1, 1, unit_word(1, 1, 1, 0));
        add_row(-1, -1, -1, 1, unit_word(-1, -1, -1, 0));
        add_row(8388607, 0, 0, 1, unit_word(1, 0, 0, 0));
        add_row(0, -8388608, 0, 1, unit_word(0, -1, 0, 0));
        add_row(0, 0, -8388608, 1, unit_word(0, 0, -1, 0));
        add_row(0, 5, 0, 1, unit_word(0, 1, 0, 0));
        add_row(0, 0, 1, 1, unit_word(0, 0, 1, 0));
        add_row(-8388608, -8388608, -8388608, 0, '0);
        add_row(8388607, 8388607, 8388607, 0, '0);
        add_row(8388607, -8388608, 8388607, 0, '0);
        add_row(3, 4, 0, 0, '0);
        add_row(1, 2, 2, 0, '0);
        add_row(-1, 0, 1, 0, '0);
        add_row(1, 8388607, 0, 0, '0);
        add_row(-2, 0, 8388607, 0, '0);
        add_row(12345, -678901, 2345678, 0, '0);
        add_row(-1, 1, 0, 0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].vec,
                      dir_rows[i].has_fixed ? dir_rows[i].fixed
                                            : normalize(dir_rows[i].vec));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 60)
            begin
                // keep offering while the receiver holds off
                hold_off = 1'b1;
            end
            if (n == 200)
            begin
                // pause until the pipe has drained completely
                in_valid <= 1'b0;
                while (expected_q.size() != 0)
                    @(negedge clk);
            end
            v = rand_vector();
            send_word(v, normalize(v));
            maybe_gap(burst);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern and long hold-off
    initial
    begin
        int pattern;
        int hold;
        out_stall = 1'b0;
        hold_off = 1'b0;
        hold = 0;
        pattern = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                hold = 150;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                pattern++;
                case ((pattern / 64) % 4)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= (pattern % 5 < 2);
                    default: out_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // result check
    always @(posedge clk)
    begin
        v3n_out_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", out_data);
            end
            else
            begin
                exp_word = expected_q.pop_front();
                if (out_data.unit_x !== exp_word.unit_x
                    || out_data.unit_y !== exp_word.unit_y
                    || out_data.unit_z !== exp_word.unit_z
                    || out_data.was_zero !== exp_word.was_zero)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d %0d %0d z%0b, got %0d %0d %0d z%0b",
                                 exp_word.unit_x, exp_word.unit_y, exp_word.unit_z,
                                 exp_word.was_zero, out_data.unit_x, out_data.unit_y,
                                 out_data.unit_z, out_data.was_zero);
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/v3n_pkg.sv
rtl/core/v3n_sqrt.sv
rtl/core/v3n_lane.sv
rtl/core/vector3_normalizer.sv
bench/testbench.sv
